### src/vlc_pkg.sv
// Shared types and constants of the Vigenere letter cipher.
package vlc_pkg;

    localparam int LETTER_W = 5;
    localparam int BYTE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int SLOT_W   = 6;
    localparam int KLEN_W   = 7;
    localparam int REG_IDX_W = 1;

    typedef logic [LETTER_W-1:0] letter_t;

    // Command codes of an input transaction
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ENCRYPT_MODE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH   = 1'd1;

    localparam logic [5:0]        ALPHA_SIZE  = 6'd26;
    localparam logic [BYTE_W-1:0] CASE_BIT    = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_LC_A  = 8'h61;
    localparam logic [BYTE_W-1:0] ASCII_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_A      = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z      = 7'h5A;

    // One queued letter: plain letter index and the raw key letter
    typedef struct packed {
        letter_t plain;
        letter_t key;
    } vlc_entry_t;

endpackage

### src/vlc_item_if.sv
// Input channel: key load and text byte transactions.
interface vlc_item_if;
    import vlc_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [SLOT_W-1:0]   key_slot;
    logic [LETTER_W-1:0] key_letter;
    logic [BYTE_W-1:0]   text_byte;
    logic                start_of_message;

    modport source (
        output valid, command, key_slot, key_letter, text_byte, start_of_message,
        input  ready
    );
    modport sink (
        input  valid, command, key_slot, key_letter, text_byte, start_of_message,
        output ready
    );
endinterface

### src/vlc_char_if.sv
// Result channel: one cipher letter per transaction.
interface vlc_char_if;
    import vlc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cipher_char;

    modport source (
        output valid, cipher_char,
        input  ready
    );
    modport sink (
        input  valid, cipher_char,
        output ready
    );
endinterface

### src/vlc_cfg_if.sv
// Configuration write channel.
interface vlc_cfg_if;
    import vlc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [KLEN_W-1:0]    wdata;

    modport source (
        output valid, reg_index, wdata,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wdata,
        output ready
    );
endinterface

### src/vlc_front.sv
// Front end: accepts transactions, loads the key store, folds and filters text, tracks position.
module vlc_front
    import vlc_pkg::*;
#(
    parameter int KEY_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    vlc_item_if.sink          item,
    input  logic [KLEN_W-1:0] key_length,
    output logic              push_valid,
    input  logic              push_ready,
    output vlc_entry_t        push_data
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LW = $clog2(KEY_DEPTH + 1);
    localparam int CW = (LW > KLEN_W) ? LW : KLEN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(KEY_DEPTH);

    logic [LETTER_W-1:0] key_mem [KEY_DEPTH];

    logic [AW-1:0]       pos_reg, pos_next;
    logic                s1_valid_reg, s1_valid_next;
    letter_t             s1_plain_reg;
    letter_t             key_rd_reg;

    logic                accept;
    logic                is_text;
    logic                is_letter;
    logic                slot_ok;
    logic [BYTE_W-1:0]   folded;
    logic [BYTE_W-1:0]   plain_full;
    logic [AW-1:0]       pos_start;
    logic [AW-1:0]       pos_eff;
    logic [AW-1:0]       pos_wrap;
    logic [CW-1:0]       len_raw;
    logic [CW-1:0]       len_eff;
    logic [CW-1:0]       pos_inc;

    assign item.ready = !s1_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign is_text    = (item.command == CMD_TEXT);
    assign slot_ok    = (32'(item.key_slot) < 32'(KEY_DEPTH));

    always_comb
    begin
        folded = item.text_byte;
        if (item.text_byte inside {[ASCII_LC_A:ASCII_LC_Z]})
        begin
            folded = item.text_byte & ~CASE_BIT;
        end
        is_letter  = folded inside {[ASCII_UC_A:ASCII_UC_Z]};
        plain_full = folded - ASCII_UC_A;
    end

    // Clamp the configured length into 1..KEY_DEPTH
    always_comb
    begin
        len_raw = CW'(key_length);
        if (len_raw == '0)
        begin
            len_eff = CW'(1);
        end
        else if (len_raw > DEPTH_C)
        begin
            len_eff = DEPTH_C;
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    always_comb
    begin
        pos_start = item.start_of_message ? '0 : pos_reg;
        pos_eff   = (CW'(pos_start) >= len_eff) ? '0 : pos_start;
        pos_inc   = CW'(pos_eff) + CW'(1);
        pos_wrap  = (pos_inc >= len_eff) ? '0 : AW'(pos_inc);

        pos_next = pos_reg;
        if (accept && is_text)
        begin
            pos_next = is_letter ? pos_wrap : pos_start;
        end

        s1_valid_next = s1_valid_reg;
        if (item.ready)
        begin
            s1_valid_next = accept && is_text && is_letter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Key store: one write port for loads, one registered read port for letters
    always_ff @(posedge clk)
    begin
        if (accept && !is_text && slot_ok)
        begin
            key_mem[AW'(item.key_slot)] <= item.key_letter;
        end
        if (accept && is_text && is_letter)
        begin
            key_rd_reg   <= key_mem[pos_eff];
            s1_plain_reg <= LETTER_W'(plain_full);
        end
    end

    assign push_valid      = s1_valid_reg;
    assign push_data.plain = s1_plain_reg;
    assign push_data.key   = key_rd_reg;

    a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(KEY_DEPTH))
        else $error("key position past the key store");

endmodule

### src/vlc_queue.sv
// Two-entry queue between the front and back ends.
module vlc_queue
    import vlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  vlc_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output vlc_entry_t pop_data
);

    vlc_entry_t slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

### src/vlc_back.sv
// Back end: shifts each queued letter by its key letter and holds the result.
module vlc_back
    import vlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       encrypt_mode,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  vlc_entry_t pop_data,
    vlc_char_if.source result
);

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    letter_t           key_mod;
    logic [5:0]        sum;
    letter_t           shifted;

    assign pop_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        // Key letters above Z wrap once
        key_mod = (6'(pop_data.key) >= ALPHA_SIZE) ?
                  LETTER_W'(6'(pop_data.key) - ALPHA_SIZE) : pop_data.key;
        if (encrypt_mode)
        begin
            sum = 6'(pop_data.plain) + 6'(key_mod);
        end
        else
        begin
            sum = 6'(pop_data.plain) + ALPHA_SIZE - 6'(key_mod);
        end
        shifted = (sum >= ALPHA_SIZE) ? LETTER_W'(sum - ALPHA_SIZE) : LETTER_W'(sum);

        out_valid_next = pop_ready ? pop_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            char_reg <= CHAR_A + CHAR_W'(shifted);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.cipher_char = char_reg;

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg >= CHAR_A && char_reg <= CHAR_Z))
        else $error("result outside A to Z");

endmodule

### src/vlc_top.sv
// Top level of the Vigenere letter cipher: configuration registers and the front/queue/back chain.
//
//  channel  | role   | payload                                                  | handshake
//  ---------+--------+----------------------------------------------------------+-------------
//  item     | sink   | command, key_slot, key_letter, text_byte, start_of_message| valid/ready
//  result   | source | cipher_char                                              | valid/ready
//  cfg      | sink   | reg_index (0 encrypt_mode, 1 key_length), wdata          | valid/ready
//
//  One transaction is accepted every cycle while the result side drains.
//  A kept letter passes the key store read register, then the queue, then the output
//  register, which raises result.valid. Loads and dropped bytes give no result.
//  rst_n clears position, queue and valid flags; encrypt_mode resets to 1 and
//  key_length to 1. The key store is not cleared and must be loaded before use.
//  A stall on result backs up the output register, then the queue, then the front.
module vigenere_letter_cipher_top
    import vlc_pkg::*;
#(
    parameter int KEY_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    vlc_item_if.sink  item,
    vlc_char_if.source result,
    vlc_cfg_if.sink   cfg
);

    logic              encrypt_mode_reg, encrypt_mode_next;
    logic [KLEN_W-1:0] key_length_reg, key_length_next;

    logic       push_valid;
    logic       push_ready;
    vlc_entry_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    vlc_entry_t pop_data;

    // Configuration writes are always taken; an unknown index is dropped
    assign cfg.ready = 1'b1;

    always_comb
    begin
        encrypt_mode_next = encrypt_mode_reg;
        key_length_next   = key_length_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_ENCRYPT_MODE: encrypt_mode_next = cfg.wdata[0];
                REG_KEY_LENGTH:   key_length_next   = cfg.wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encrypt_mode_reg <= 1'b1;
            key_length_reg   <= KLEN_W'(1);
        end
        else
        begin
            encrypt_mode_reg <= encrypt_mode_next;
            key_length_reg   <= key_length_next;
        end
    end

    // Front: accept, load keys, fold case, drop non-letters, advance position
    vlc_front #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .key_length (key_length_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue: decouple the front from back-pressure on the result side
    vlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: shift modulo 26 and hold the letter until taken
    vlc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .encrypt_mode (encrypt_mode_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result       (result)
    );

endmodule

### bench/tb.sv
// Self-checking testbench for the Vigenere letter cipher top level.
`timescale 1ns / 100ps

module tb;
    import vlc_pkg::*;

    localparam int TB_KEY_DEPTH  = 64;
    localparam int SETTLE_CYCLES = 8;        // covers the three-stage path with margin
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1550;

    // One input transaction as the driver presents it
    typedef struct packed {
        logic                command;
        logic [SLOT_W-1:0]   slot;
        letter_t             letter;
        logic [BYTE_W-1:0]   text;
        logic                som;
    } cipher_item_t;

    logic clk;
    logic rst_n;

    vlc_item_if item_ch ();
    vlc_char_if res_ch ();
    vlc_cfg_if  cfg_ch ();

    vigenere_letter_cipher_top #(
        .KEY_DEPTH (TB_KEY_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Transactions waiting for the driver, and cipher letters waiting for the monitor
    cipher_item_t         pending[$];
    logic [CHAR_W-1:0]    char_expected[$];

    // Predicted cipher state: key store, key position and the two registers
    letter_t              key_mem [TB_KEY_DEPTH];
    int                   key_pos;
    logic                 enc_mode;
    logic [KLEN_W-1:0]    key_len;

    int                   mismatch_count;
    int                   cycle_count;
    logic                 item_taken;
    int                   item_gap;
    int                   stall_left;
    bit                   steady_items;
    bit                   steady_ready;

    // Free-running 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hold reset low from time zero, release it on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Drive every input to a known value from time zero
    initial
    begin
        item_ch.valid            = 1'b0;
        item_ch.command          = CMD_LOAD;
        item_ch.key_slot         = '0;
        item_ch.key_letter       = '0;
        item_ch.text_byte        = '0;
        item_ch.start_of_message = 1'b0;
        res_ch.ready             = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.reg_index         = REG_ENCRYPT_MODE;
        cfg_ch.wdata             = '0;
        item_gap                 = 0;
        stall_left               = 0;
        steady_items             = 1'b0;
        steady_ready             = 1'b0;
        mismatch_count           = 0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Print one line per mismatch and count every one
    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Advance the predicted state by one accepted transaction and queue the
    // cipher letter it gives, if any
    function automatic void predict_cipher(cipher_item_t it);
        int                eff_len;
        int                pos;
        int                shift;
        int                plain;
        int                sum;
        logic [BYTE_W-1:0] folded;
        if (it.command == CMD_LOAD)
        begin
            key_mem[it.slot] = it.letter;
            return;
        end
        // A start flag clears the position even when the byte is dropped
        if (it.som)
            key_pos = 0;
        folded = it.text;
        if (folded >= ASCII_LC_A && folded <= ASCII_LC_Z)
            folded = folded & ~CASE_BIT;
        if (folded < ASCII_UC_A || folded > ASCII_UC_Z)
            return;
        // Length zero acts as one; anything past the store saturates
        if (key_len == 0)
            eff_len = 1;
        else if (key_len > TB_KEY_DEPTH)
            eff_len = TB_KEY_DEPTH;
        else
            eff_len = key_len;
        // A position stranded past a lowered length counts as zero
        pos = (key_pos >= eff_len) ? 0 : key_pos;
        shift = key_mem[pos] % ALPHA_SIZE;
        plain = folded - ASCII_UC_A;
        if (enc_mode)
            sum = plain + shift;
        else
            sum = plain + ALPHA_SIZE - shift;
        char_expected.push_back(CHAR_W'(CHAR_A + (sum % ALPHA_SIZE)));
        pos++;
        if (pos >= eff_len)
            pos = 0;
        key_pos = pos;
    endfunction

    // Input driver: present the next pending transaction once the slot is
    // free, with a random gap between transactions except in steady stretches
    always @(negedge clk)
    begin : drive_items
        cipher_item_t next_item;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_taken)
        begin
            if (item_gap > 0)
            begin
                item_ch.valid <= 1'b0;
                item_gap--;
            end
            else if (pending.size() != 0)
            begin
                next_item = pending.pop_front();
                item_ch.command          <= next_item.command;
                item_ch.key_slot         <= next_item.slot;
                item_ch.key_letter       <= next_item.letter;
                item_ch.text_byte        <= next_item.text;
                item_ch.start_of_message <= next_item.som;
                item_ch.valid            <= 1'b1;
                item_gap = steady_items ? 0 : draw_gap();
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Result back-pressure: stall the output at random, except in steady stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (!steady_ready && $urandom_range(0, 99) < 25)
                stall_left = draw_gap();
        end
    end

    // Monitor: sample all three channels at the rising edge; update the
    // prediction on accepted inputs, check accepted results against the
    // oldest expectation
    always @(posedge clk)
    begin
        item_taken <= item_ch.valid && item_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.reg_index)
                    REG_ENCRYPT_MODE: enc_mode = cfg_ch.wdata[0];
                    REG_KEY_LENGTH:   key_len  = cfg_ch.wdata;
                    default:          ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
                predict_cipher({item_ch.command, item_ch.key_slot, item_ch.key_letter,
                                item_ch.text_byte, item_ch.start_of_message});
            if (res_ch.valid && res_ch.ready)
            begin
                if (char_expected.size() == 0)
                    report_mismatch("unexpected cipher_char", res_ch.cipher_char, 0);
                else if (res_ch.cipher_char !== char_expected[0])
                    report_mismatch("cipher_char", res_ch.cipher_char,
                                    char_expected.pop_front());
                else
                    void'(char_expected.pop_front());
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Queue a key load; the text fields ride along with random content
    task automatic queue_load(int slot, int letter);
        cipher_item_t it;
        it.command = CMD_LOAD;
        it.slot    = SLOT_W'(slot);
        it.letter  = LETTER_W'(letter);
        it.text    = BYTE_W'($urandom_range(0, 255));
        it.som     = 1'($urandom_range(0, 1));
        pending.push_back(it);
    endtask

    // Queue a text byte; the key fields ride along with random content
    task automatic queue_text(int text, bit som);
        cipher_item_t it;
        it.command = CMD_TEXT;
        it.slot    = SLOT_W'($urandom_range(0, TB_KEY_DEPTH - 1));
        it.letter  = LETTER_W'($urandom_range(0, 31));
        it.text    = BYTE_W'(text);
        it.som     = som;
        pending.push_back(it);
    endtask

    // Write one register and hold valid until the write is taken
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [KLEN_W-1:0] data);
        @(negedge clk);
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        cfg_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every transaction is taken and every letter has come back,
    // then give the pipeline time to empty
    task automatic wait_idle();
        while (pending.size() != 0 || item_ch.valid || char_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random key letter: mostly A..Z, sometimes the out-of-range codes
    function automatic int draw_key_letter();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 25);
        return $urandom_range(26, 31);
    endfunction

    // Stimulus: a directed opening, then phases of register writes, key
    // loads and messages until enough random traffic has gone through
    initial
    begin : stimulus
        bit key_written [TB_KEY_DEPTH];
        int random_count;
        int phase;
        int new_mode;
        int new_len;
        int eff_len;
        int msg_len;
        int pick;
        int letter;
        bit reload;
        bit som_first;

        key_pos      = 0;
        enc_mode     = 1'b1;
        key_len      = KLEN_W'(1);
        cycle_count  = 0;
        random_count = 0;
        foreach (key_written[i])
            key_written[i] = 1'b0;

        while (rst_n !== 1'b1)
            @(posedge clk);

        // Directed: reset registers (encrypt, length one), field extremes,
        // case folding, dropped bytes and key letters past Z
        queue_load(0, 3);
        queue_load(TB_KEY_DEPTH - 1, 31);
        key_written[0] = 1'b1;
        key_written[TB_KEY_DEPTH - 1] = 1'b1;
        queue_text("A", 1'b1);
        queue_text("Z", 1'b0);
        queue_text("a", 1'b0);
        queue_text("z", 1'b0);
        queue_text(8'h40, 1'b0);      // just below A
        queue_text(8'h5B, 1'b0);      // just above Z
        queue_text(8'h60, 1'b0);      // just below a
        queue_text(8'h7B, 1'b0);      // just above z
        queue_text(8'h00, 1'b1);      // dropped byte carrying a start flag
        queue_text(8'hFF, 1'b0);
        queue_text(8'hC1, 1'b0);      // A with the top bit set: dropped
        queue_text(8'hE1, 1'b0);      // a with the top bit set: dropped
        queue_load(0, 25);
        queue_text("y", 1'b0);
        queue_load(0, 26);            // acts as A
        queue_text("M", 1'b0);
        queue_load(0, 31);            // acts as F
        queue_text("m", 1'b1);
        wait_idle();

        // Random phases; the first few hit the register extremes
        phase = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            case (phase)
                0:       begin new_mode = 0; new_len = 0;   end
                1:       begin new_mode = 1; new_len = 127; end
                2:       begin new_mode = 0; new_len = 64;  end
                3:       begin new_mode = 1; new_len = 65;  end
                4:       begin new_mode = 1; new_len = 1;   end
                5:       begin new_mode = 0; new_len = 2;   end
                default:
                begin
                    new_mode = $urandom_range(0, 1);
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        new_len = $urandom_range(1, 12);
                    else if (pick < 90)
                        new_len = $urandom_range(13, 64);
                    else if (pick < 95)
                        new_len = 0;
                    else
                        new_len = $urandom_range(65, 127);
                end
            endcase

            // Vary the idling per phase: some phases run with no gaps or stalls
            steady_items = ($urandom_range(0, 3) == 0);
            steady_ready = ($urandom_range(0, 3) == 0);

            // Write both registers in random order; the unused mode bits get noise
            if ($urandom_range(0, 1))
            begin
                write_register(REG_ENCRYPT_MODE, {6'($urandom_range(0, 63)), 1'(new_mode)});
                write_register(REG_KEY_LENGTH, KLEN_W'(new_len));
            end
            else
            begin
                write_register(REG_KEY_LENGTH, KLEN_W'(new_len));
                write_register(REG_ENCRYPT_MODE, {6'($urandom_range(0, 63)), 1'(new_mode)});
            end

            if (new_len == 0)
                eff_len = 1;
            else if (new_len > TB_KEY_DEPTH)
                eff_len = TB_KEY_DEPTH;
            else
                eff_len = new_len;

            // Load every key slot in use that was never written; often reload
            // the whole key with fresh letters
            reload = 1'($urandom_range(0, 1));
            for (int s = 0; s < eff_len; s++)
            begin
                if (reload || !key_written[s])
                begin
                    queue_load(s, draw_key_letter());
                    key_written[s] = 1'b1;
                    random_count++;
                end
            end

            // Message: mostly letters of either case, some noise bytes and
            // stray loads; skip the opening start flag now and then so the
            // old position carries over into the new length
            som_first = ($urandom_range(0, 3) != 0);
            msg_len = $urandom_range(20, 80);
            for (int n = 0; n < msg_len; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    queue_text("A" + $urandom_range(0, 25),
                               (n == 0) ? som_first : ($urandom_range(0, 99) < 3));
                    random_count++;
                end
                else if (pick < 82)
                begin
                    queue_text("a" + $urandom_range(0, 25),
                               (n == 0) ? som_first : ($urandom_range(0, 99) < 3));
                    random_count++;
                end
                else if (pick < 93)
                begin
                    queue_text($urandom_range(0, 255), (n == 0) ? som_first :
                               ($urandom_range(0, 99) < 5));
                    random_count++;
                end
                else
                begin
                    letter = $urandom_range(0, TB_KEY_DEPTH - 1);
                    queue_load(letter, draw_key_letter());
                    key_written[letter] = 1'b1;
                    random_count++;
                end
            end

            wait_idle();
            phase++;
        end

        // Drain and give any stray result time to show up
        steady_items = 1'b0;
        steady_ready = 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && char_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
